// ===== rtl/pbump_pkg.sv =====
// Shared types, codes and constants of the page bump allocator.
package pbump_pkg;

  localparam int unsigned PageBytesDefault = 4096;

  localparam logic [63:0] LowLimit   = 64'h0000_0000_0010_0000;
  localparam logic [31:0] TypeUsable = 32'd1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_ALLOC = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_REFUSED = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] map_base;
    logic [63:0] map_length;
    logic [31:0] map_type;
    logic [31:0] request_size;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_address;
    logic [31:0] region_start;
    logic [31:0] region_size;
    logic [31:0] bytes_used;
  } result_t;

endpackage

// ===== rtl/pbump_in_if.sv =====
// Input channel of the page bump allocator.
interface pbump_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] map_base;
  logic [63:0] map_length;
  logic [31:0] map_type;
  logic [31:0] request_size;

  modport source (output valid, kind, map_base, map_length, map_type, request_size,
                  input ready);
  modport sink (input valid, kind, map_base, map_length, map_type, request_size,
                output ready);
endinterface

// ===== rtl/pbump_out_if.sv =====
// Result channel of the page bump allocator.
interface pbump_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] grant_address;
  logic [31:0] region_start;
  logic [31:0] region_size;
  logic [31:0] bytes_used;

  modport source (output valid, status, grant_address, region_start, region_size,
                  bytes_used, input ready);
  modport sink (input valid, status, grant_address, region_start, region_size,
                bytes_used, output ready);
endinterface

// ===== rtl/pbump_in_reg.sv =====
// Input register stage that holds one accepted word for the core.
module pbump_in_reg
  import pbump_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pbump_in_if.sink   in_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_ready_i
);

  logic  full_q, full_d;
  item_t item_q;
  logic  in_fire;

  assign in_i.ready   = !full_q || item_ready_i;
  assign in_fire      = in_i.valid && in_i.ready;
  assign full_d       = in_fire || (full_q && !item_ready_i);
  assign item_valid_o = full_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{kind:         in_i.kind,
                  map_base:     in_i.map_base,
                  map_length:   in_i.map_length,
                  map_type:     in_i.map_type,
                  request_size: in_i.request_size};
    end
  end

endmodule

// ===== rtl/pbump_core.sv =====
// Region state, entry selection and allocation logic with the result register.
module pbump_core
  import pbump_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PageBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_ready_o,
  pbump_out_if.source out_o
);

  localparam logic [31:0] PageMask = 32'(PAGE_BYTES - 1);

  logic [31:0] base_q, base_d;
  logic [31:0] cap_q, cap_d;
  logic [31:0] used_q, used_d;
  logic        valid_q;
  result_t     res_q, res_d;
  logic        advance;

  logic [31:0] ubase;
  logic [32:0] rem33;
  logic        clip;
  logic [31:0] usize;
  logic [32:0] bsum;
  logic [31:0] abase;
  logic [31:0] lead;
  logic [31:0] net_size;
  logic        keep;
  logic        entry_ok;
  logic [32:0] ssum;
  logic [31:0] asize;
  logic [31:0] space;
  logic        alloc_ok;

  assign item_ready_o = !valid_q || out_o.ready;
  assign advance      = item_valid_i && item_ready_o;

  always_comb begin
    ubase    = item_i.map_base[31:0];
    keep     = (item_i.map_type == TypeUsable) && (item_i.map_base >= LowLimit) &&
               (item_i.map_base[63:32] == 32'd0);
    rem33    = 33'h1_0000_0000 - {1'b0, ubase};
    clip     = (item_i.map_length[63:32] != 32'd0) ||
               ({1'b0, item_i.map_length[31:0]} >= rem33);
    usize    = clip ? rem33[31:0] : item_i.map_length[31:0];
    bsum     = {1'b0, ubase} + {1'b0, PageMask};
    abase    = bsum[31:0] & ~PageMask;
    lead     = abase - ubase;
    net_size = usize - lead;
    entry_ok = keep && !bsum[32] && (abase != 32'd0) && (lead < usize) &&
               (net_size > cap_q);

    ssum     = {1'b0, item_i.request_size} + {1'b0, PageMask};
    asize    = ssum[31:0] & ~PageMask;
    space    = cap_q - used_q;
    alloc_ok = (cap_q != 32'd0) && (item_i.request_size != 32'd0) && !ssum[32] &&
               (asize != 32'd0) && (used_q <= cap_q) && (asize <= space);
  end

  always_comb begin
    base_d = base_q;
    cap_d  = cap_q;
    used_d = used_q;
    res_d.status        = STATUS_IGNORED;
    res_d.grant_address = 32'd0;
    unique case (item_i.kind)
      KIND_CLEAR: begin
        base_d       = 32'd0;
        cap_d        = 32'd0;
        used_d       = 32'd0;
        res_d.status = STATUS_OK;
      end
      KIND_ENTRY: begin
        if (entry_ok) begin
          base_d       = abase;
          cap_d        = net_size & ~PageMask;
          res_d.status = STATUS_OK;
        end
      end
      KIND_ALLOC: begin
        if (alloc_ok) begin
          res_d.grant_address = base_q + used_q;
          used_d              = used_q + asize;
          res_d.status        = STATUS_OK;
        end else begin
          res_d.status = STATUS_REFUSED;
        end
      end
      default: begin
        res_d.status = STATUS_IGNORED;
      end
    endcase
    res_d.region_start = base_d;
    res_d.region_size  = cap_d;
    res_d.bytes_used   = used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 32'd0;
      cap_q   <= 32'd0;
      used_q  <= 32'd0;
      valid_q <= 1'b0;
    end else begin
      if (advance) begin
        base_q  <= base_d;
        cap_q   <= cap_d;
        used_q  <= used_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.grant_address = res_q.grant_address;
  assign out_o.region_start  = res_q.region_start;
  assign out_o.region_size   = res_q.region_size;
  assign out_o.bytes_used    = res_q.bytes_used;

  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= cap_q)
    else $error("Used bytes exceed the region capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (cap_q & PageMask) == 32'd0)
    else $error("Region capacity is not a whole number of pages.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   advance && (item_i.kind == KIND_CLEAR) |=>
                   (cap_q == 32'd0) && (used_q == 32'd0) && (base_q == 32'd0))
    else $error("Clear word did not empty the region.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_q && (res_q.grant_address != 32'd0) |->
                   (res_q.status == STATUS_OK))
    else $error("Grant address reported without a grant.");

endmodule

// ===== rtl/page_bump_allocator_top.sv =====
// The page bump allocator accepts one word per cycle while its results are taken. Each word
// is held in the input register and its result in the result register, with all region and
// allocation logic between them. While a finished result waits to be taken, the input side
// takes one more word into the input register and then holds ready low until the result is
// taken. Input ready follows result ready within the same cycle.
module page_bump_allocator_top
  import pbump_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbump_in_if.sink    in_i,
  pbump_out_if.source out_o
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  pbump_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  pbump_core #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule
